FILE: hdl/ecgre_pkg.sv
// shared types and constants of the relative energy filter
// no dependencies
package ecgre_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned EnergyW = 32;
  localparam logic [15:0] SCALE_RESET = 16'd10000;
  localparam logic [15:0] COEF_MAX = 16'hffff;
  localparam logic signed [15:0] Y_MAX = 16'sh7fff;
  localparam logic signed [15:0] Y_MIN = 16'sh8000;

  // one classified item as it travels from front to back
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      warm;
    logic                      in_short;
    logic                      last;
  } cmd_t;

endpackage

FILE: hdl/ecg_relative_energy_filter_top.sv
// top level of the relative energy qrs enhancement filter
// depends on ecgre_pkg, ecgre_front, ecgre_queue, ecgre_back
//
// usage:
// - input channel in_valid_i / in_stall_o carries one signed sample per item;
//   output channel out_valid_o / out_stall_i carries one result per item
// - scale is written through cfg_valid_i / cfg_ready_o / cfg_data_i; the user
//   must write it only while the block is idle (not enforced); it resets to 10000
// - the front classifies each sample (warm-up, short window, end of warm-up)
//   and hands it through a two-entry queue to the back end
// - warm-up items, the first LONG_LEN items, answer zero with warming_up_o set
// - steady items use the shared bit-serial 32-bit divider twice when long
//   energy does not exceed scale and three times otherwise
// - items with zero long energy or zero scale skip the divider and answer zero
// - reset clears all energies and sets the indices to their start values; the ring needs no clearing pass
// - when out_stall_i holds a result, the back end waits with the next result
//   and the queue keeps taking input until it is full
module ecg_relative_energy_filter_top #(
  parameter int unsigned LONG_LEN   = 256,
  parameter int unsigned SHORT_HALF = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] enhanced_sample_o,
  output logic [15:0]        coefficient_o,
  output logic               warming_up_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);
  import ecgre_pkg::*;

  localparam int unsigned QDepth = 2;

  cmd_t        push_cmd, head_cmd;
  logic        push, pop, q_full, q_empty;
  logic [15:0] scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      scale_q <= cfg_data_i;
    end
  end

  ecgre_front #(
    .LONG_LEN  (LONG_LEN),
    .SHORT_HALF(SHORT_HALF)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sample_i  (sample_i),
    .push_o    (push),
    .cmd_o     (push_cmd),
    .full_i    (q_full)
  );

  ecgre_queue #(
    .DEPTH(QDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .pop_i  (pop),
    .data_o (head_cmd),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  ecgre_back #(
    .LONG_LEN  (LONG_LEN),
    .SHORT_HALF(SHORT_HALF)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (head_cmd),
    .empty_i          (q_empty),
    .pop_o            (pop),
    .scale_i          (scale_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .enhanced_sample_o(enhanced_sample_o),
    .coefficient_o    (coefficient_o),
    .warming_up_o     (warming_up_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("queue read while empty");

  a_warm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && warming_up_o) |-> (coefficient_o == '0 && enhanced_sample_o == '0))
    else $error("warm-up result not zero");

  a_zero_coef: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && coefficient_o == '0) |-> (enhanced_sample_o == '0))
    else $error("nonzero output with zero coefficient");
`endif
endmodule

FILE: hdl/ecgre_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module ecgre_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 257
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: hdl/ecgre_front.sv
// front end: accepts samples and classifies them against the warm-up window
// depends on ecgre_pkg
module ecgre_front #(
  parameter int unsigned LONG_LEN   = 256,
  parameter int unsigned SHORT_HALF = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_i,
  output logic               push_o,
  output ecgre_pkg::cmd_t    cmd_o,
  input  logic               full_i
);
  import ecgre_pkg::*;

  localparam int unsigned CW = $clog2(LONG_LEN);
  localparam int Lo = int'(LONG_LEN / 2) - int'(SHORT_HALF);
  localparam int Hi = int'(LONG_LEN / 2) + int'(SHORT_HALF);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          filling_q, filling_d;
  logic          accept;
  logic          at_last;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign at_last    = (cnt_q == CW'(LONG_LEN - 1));

  always_comb begin
    cmd_o.sample   = sample_i;
    cmd_o.warm     = filling_q;
    cmd_o.in_short = filling_q && (int'(cnt_q) >= Lo) && (int'(cnt_q) <= Hi);
    cmd_o.last     = filling_q && at_last;
    cnt_d          = cnt_q;
    filling_d      = filling_q;
    if (accept && filling_q) begin
      cnt_d = cnt_q + 1'b1;
      if (at_last) begin
        filling_d = 1'b0;
      end
    end
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      filling_q <= 1'b1;
    end else begin
      cnt_q     <= cnt_d;
      filling_q <= filling_d;
    end
  end
endmodule

FILE: hdl/ecgre_queue.sv
// short fifo between front and back
// depends on ecgre_pkg
module ecgre_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ecgre_pkg::cmd_t data_i,
  input  logic            pop_i,
  output ecgre_pkg::cmd_t data_o,
  output logic            full_o,
  output logic            empty_o
);
  import ecgre_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  cmd_t          buf_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [NW-1:0] cnt_q;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

FILE: hdl/ecgre_div.sv
// 32-bit unsigned restoring divider, one quotient bit per cycle
// no dependencies
module ecgre_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, quo_q, den_q;
  logic [32:0] rem_sh, rem_sub;
  logic        fits;

  assign rem_sh  = {rem_q, quo_q[31]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[31:0] : rem_sh[31:0];
      quo_q <= {quo_q[30:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

FILE: hdl/ecgre_back.sv
// back end: sample ring, sliding energies, coefficient and output scaling
// depends on ecgre_pkg, ecgre_ram, ecgre_div
module ecgre_back #(
  parameter int unsigned LONG_LEN   = 256,
  parameter int unsigned SHORT_HALF = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ecgre_pkg::cmd_t    cmd_i,
  input  logic               empty_i,
  output logic               pop_o,
  input  logic [15:0]        scale_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] enhanced_sample_o,
  output logic [15:0]        coefficient_o,
  output logic               warming_up_o
);
  import ecgre_pkg::*;

  localparam int unsigned Ring = LONG_LEN + 1;
  localparam int unsigned IW = $clog2(Ring);
  localparam int Lo = int'(LONG_LEN / 2) - int'(SHORT_HALF);
  localparam int Hi = int'(LONG_LEN / 2) + int'(SHORT_HALF);
  localparam int SeStart = ((Hi + 1) % int'(Ring) + int'(Ring)) % int'(Ring);
  localparam int SlStart = (Lo % int'(Ring) + int'(Ring)) % int'(Ring);
  localparam int DStart = int'(LONG_LEN / 2) % int'(Ring);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_GATHER = 3'd1;
  localparam logic [2:0] ST_COEF   = 3'd2;
  localparam logic [2:0] ST_DIV1   = 3'd3;
  localparam logic [2:0] ST_DIV2   = 3'd4;
  localparam logic [2:0] ST_MULY   = 3'd5;
  localparam logic [2:0] ST_DIVY   = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0]  state_q;
  logic [2:0]  step_q;
  cmd_t        cmd_q;
  logic [IW-1:0] w_q, ll_q, se_q, sl_q, d_q;
  logic [IW-1:0] w_nx, ll_nx, se_nx, sl_nx, d_nx;
  logic [31:0] long_q, short_q;
  logic [31:0] sq_q;
  logic signed [15:0] mul_a;
  logic signed [31:0] sq;
  logic signed [15:0] dly_q;
  logic [15:0] coef_q;
  logic [31:0] num_q, den_q;
  logic        go_q;
  logic        div_done;
  logic [31:0] quo;
  logic [47:0] prod;
  logic [16:0] dly_abs;
  logic [32:0] mag;
  logic signed [15:0] res_y_q;
  logic [15:0] res_coef_q;
  logic        res_warm_q;
  logic        out_vld_q;
  logic signed [15:0] out_y_q;
  logic [15:0] out_coef_q;
  logic        out_warm_q;
  logic        ram_we;
  logic [IW-1:0] raddr;
  logic [15:0] rdata;
  logic        out_free;

  assign w_nx  = (w_q == IW'(Ring - 1)) ? '0 : w_q + 1'b1;
  assign ll_nx = (ll_q == IW'(Ring - 1)) ? '0 : ll_q + 1'b1;
  assign se_nx = (se_q == IW'(Ring - 1)) ? '0 : se_q + 1'b1;
  assign sl_nx = (sl_q == IW'(Ring - 1)) ? '0 : sl_q + 1'b1;
  assign d_nx  = (d_q == IW'(Ring - 1)) ? '0 : d_q + 1'b1;

  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign ram_we   = (state_q == ST_GATHER) && (step_q == 3'd0);
  assign out_free = !out_vld_q || !out_stall_i;

  // read order: long leave, short enter, short leave, delay tap
  always_comb begin
    case (step_q)
      3'd0:    raddr = ll_q;
      3'd1:    raddr = se_q;
      3'd2:    raddr = sl_q;
      default: raddr = d_q;
    endcase
  end

  ecgre_ram #(
    .WIDTH(16),
    .DEPTH(Ring)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(w_q),
    .wdata_i(cmd_q.sample),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  ecgre_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(go_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign mul_a   = (step_q == 3'd0) ? cmd_q.sample : $signed(rdata);
  assign sq      = mul_a * mul_a;
  assign prod    = short_q * scale_i;
  assign dly_abs = dly_q[15] ? 17'(-$signed({dly_q[15], dly_q})) : {1'b0, dly_q};
  assign mag     = coef_q * dly_abs;

  always_ff @(posedge clk_i) begin
    sq_q <= sq;
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_GATHER && step_q == 3'd4) begin
      dly_q <= $signed(rdata);
    end
    if (state_q == ST_OUT && out_free) begin
      out_y_q    <= res_y_q;
      out_coef_q <= res_coef_q;
      out_warm_q <= res_warm_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      w_q        <= '0;
      ll_q       <= '0;
      se_q       <= '0;
      sl_q       <= '0;
      d_q        <= IW'(DStart);
      long_q     <= '0;
      short_q    <= '0;
      coef_q     <= '0;
      num_q      <= '0;
      den_q      <= '0;
      go_q       <= 1'b0;
      res_y_q    <= '0;
      res_coef_q <= '0;
      res_warm_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      go_q <= 1'b0;
      if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            step_q  <= '0;
            state_q <= ST_GATHER;
          end
        end
        ST_GATHER: begin
          step_q <= step_q + 1'b1;
          case (step_q)
            3'd0: begin
            end
            3'd1: begin
              long_q <= long_q + sq_q;
              if (cmd_q.warm) begin
                if (cmd_q.in_short) begin
                  short_q <= short_q + sq_q;
                end
                w_q <= w_nx;
                if (cmd_q.last) begin
                  ll_q <= '0;
                  se_q <= IW'(SeStart);
                  sl_q <= IW'(SlStart);
                  d_q  <= d_nx;
                end
                res_y_q    <= '0;
                res_coef_q <= '0;
                res_warm_q <= 1'b1;
                state_q    <= ST_OUT;
              end
            end
            3'd2: long_q <= long_q - sq_q;
            3'd3: short_q <= short_q + sq_q;
            default: begin
              short_q <= short_q - sq_q;
              w_q     <= w_nx;
              ll_q    <= ll_nx;
              se_q    <= se_nx;
              sl_q    <= sl_nx;
              d_q     <= d_nx;
              state_q <= ST_COEF;
            end
          endcase
        end
        ST_COEF: begin
          res_warm_q <= 1'b0;
          if (long_q == '0 || scale_i == '0) begin
            res_y_q    <= '0;
            res_coef_q <= '0;
            state_q    <= ST_OUT;
          end else if (long_q > {16'd0, scale_i}) begin
            num_q   <= long_q;
            den_q   <= {16'd0, scale_i};
            go_q    <= 1'b1;
            state_q <= ST_DIV1;
          end else begin
            // short*scale wraps at 32 bits
            num_q   <= prod[31:0];
            den_q   <= long_q;
            go_q    <= 1'b1;
            state_q <= ST_DIV2;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            num_q   <= short_q;
            den_q   <= quo;
            go_q    <= 1'b1;
            state_q <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            coef_q  <= (quo > {16'd0, COEF_MAX}) ? COEF_MAX : quo[15:0];
            state_q <= ST_MULY;
          end
        end
        ST_MULY: begin
          res_coef_q <= coef_q;
          num_q      <= mag[31:0];
          den_q      <= {16'd0, scale_i};
          go_q       <= 1'b1;
          state_q    <= ST_DIVY;
        end
        ST_DIVY: begin
          if (div_done) begin
            if (dly_q[15]) begin
              res_y_q <= (quo > 32'd32768) ? Y_MIN : $signed(16'(-quo[15:0]));
            end else begin
              res_y_q <= (quo > 32'd32767) ? Y_MAX : $signed(quo[15:0]);
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_vld_q;
  assign enhanced_sample_o = out_y_q;
  assign coefficient_o     = out_coef_q;
  assign warming_up_o      = out_warm_q;
endmodule
